// File: rtl/awl_pkg.sv
// Package for the assembly word lexer: token kinds, DFA node codes,
// status codes and the per-character classification functions.
// Depends on nothing; used by assembly_word_lexer.
`default_nettype none

package awl_pkg;

  // Longest word length that is counted before the count saturates.
  localparam int MAX_WORD_LENGTH = 255;
  localparam logic [7:0] LEN_CAP =
    8'((MAX_WORD_LENGTH < 255) ? MAX_WORD_LENGTH : 255);

  // Largest byte code that counts as whitespace.
  localparam logic [7:0] SPACE_MAX = 8'd32;

  typedef logic [4:0] node_t;
  typedef logic [4:0] kind_t;
  typedef logic [1:0] status_t;

  // Keyword DFA nodes: the root, one node per mnemonic, and the dead node.
  localparam node_t NODE_ROOT = 5'd0;
  localparam node_t NODE_BR   = 5'd1;
  localparam node_t NODE_LD   = 5'd2;
  localparam node_t NODE_STR  = 5'd3;
  localparam node_t NODE_OUT  = 5'd4;
  localparam node_t NODE_ADD  = 5'd5;
  localparam node_t NODE_SUB  = 5'd6;
  localparam node_t NODE_MUL  = 5'd7;
  localparam node_t NODE_DIV  = 5'd8;
  localparam node_t NODE_INC  = 5'd9;
  localparam node_t NODE_DEC  = 5'd10;
  localparam node_t NODE_BE   = 5'd11;
  localparam node_t NODE_BN   = 5'd12;
  localparam node_t NODE_BG   = 5'd13;
  localparam node_t NODE_BS   = 5'd14;
  localparam node_t NODE_BGE  = 5'd15;
  localparam node_t NODE_BSE  = 5'd16;
  localparam node_t NODE_DEAD = 5'd31;

  // Token kinds other than the mnemonics, which share the node codes.
  localparam kind_t KIND_UNKNOWN = 5'd0;
  localparam kind_t KIND_INT     = 5'd17;
  localparam kind_t KIND_REG     = 5'd18;
  localparam kind_t KIND_LABEL   = 5'd19;

  // Integer literal recognizer states.
  localparam status_t INT_EMPTY   = 2'd0;
  localparam status_t INT_ZERO    = 2'd1;
  localparam status_t INT_DIGITS  = 2'd2;
  localparam status_t INT_NONE    = 2'd3;

  // Register name recognizer states.
  localparam status_t REG_EMPTY   = 2'd0;
  localparam status_t REG_R       = 2'd1;
  localparam status_t REG_R_DIGIT = 2'd2;
  localparam status_t REG_NONE    = 2'd3;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_label_start(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           (c == "_") || (c == "$");
  endfunction

  // Length in bytes of the mnemonic that a node stands for.
  function automatic logic [1:0] mnem_len(input node_t node);
    logic [1:0] len;
    case (node)
      NODE_BR, NODE_LD, NODE_BE, NODE_BN, NODE_BG, NODE_BS: len = 2'd2;
      default: len = 2'd3;
    endcase
    return len;
  endfunction

  // One step of the keyword trie. pos is the number of bytes already in
  // the word; a node names the lowest mnemonic that still matches, or the
  // mnemonic that the word equals when it has that length.
  function automatic node_t next_node(input node_t node, input logic [7:0] pos,
                                      input logic [7:0] c);
    node_t r;
    r = NODE_DEAD;
    if (pos == 8'd0) begin
      if (node == NODE_ROOT) begin
        case (c)
          "b": r = NODE_BR;
          "l": r = NODE_LD;
          "s": r = NODE_STR;
          "o": r = NODE_OUT;
          "a": r = NODE_ADD;
          "m": r = NODE_MUL;
          "d": r = NODE_DIV;
          "i": r = NODE_INC;
          default: r = NODE_DEAD;
        endcase
      end
    end else if (pos == 8'd1) begin
      case (node)
        NODE_BR: begin
          case (c)
            "r": r = NODE_BR;
            "e": r = NODE_BE;
            "n": r = NODE_BN;
            "g": r = NODE_BG;
            "s": r = NODE_BS;
            default: r = NODE_DEAD;
          endcase
        end
        NODE_LD:  r = (c == "d") ? NODE_LD : NODE_DEAD;
        NODE_STR: begin
          case (c)
            "t": r = NODE_STR;
            "u": r = NODE_SUB;
            default: r = NODE_DEAD;
          endcase
        end
        NODE_OUT: r = (c == "u") ? NODE_OUT : NODE_DEAD;
        NODE_ADD: r = (c == "d") ? NODE_ADD : NODE_DEAD;
        NODE_MUL: r = (c == "u") ? NODE_MUL : NODE_DEAD;
        NODE_DIV: begin
          case (c)
            "i": r = NODE_DIV;
            "e": r = NODE_DEC;
            default: r = NODE_DEAD;
          endcase
        end
        NODE_INC: r = (c == "n") ? NODE_INC : NODE_DEAD;
        default:  r = NODE_DEAD;
      endcase
    end else if (pos == 8'd2) begin
      case (node)
        NODE_BG:  r = (c == "e") ? NODE_BGE : NODE_DEAD;
        NODE_BS:  r = (c == "e") ? NODE_BSE : NODE_DEAD;
        NODE_STR: r = (c == "r") ? NODE_STR : NODE_DEAD;
        NODE_SUB: r = (c == "b") ? NODE_SUB : NODE_DEAD;
        NODE_OUT: r = (c == "t") ? NODE_OUT : NODE_DEAD;
        NODE_ADD: r = (c == "d") ? NODE_ADD : NODE_DEAD;
        NODE_MUL: r = (c == "l") ? NODE_MUL : NODE_DEAD;
        NODE_DIV: r = (c == "v") ? NODE_DIV : NODE_DEAD;
        NODE_DEC: r = (c == "c") ? NODE_DEC : NODE_DEAD;
        NODE_INC: r = (c == "c") ? NODE_INC : NODE_DEAD;
        default:  r = NODE_DEAD;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/assembly_word_lexer.sv
// Assembly word lexer: splits a byte stream into whitespace-separated words
// and emits one classified token per word. Depends on awl_pkg.
`default_nettype none

//  channel  handshake            payload
//  input    in_valid/in_ready    char_code[7:0]
//  output   out_valid/out_ready  token_kind[4:0], word_length[7:0]
//
// One byte a cycle sustained while no token waits at a word end: a byte
// enters the input register, from which the per-character DFA updates the
// word state and, on whitespace ending a word, loads the result register.
// Only a word-ending byte waits for a free result register; other bytes
// pass while a token is still waiting. Reset is synchronous and clears the
// word state and both valid flags.

module assembly_word_lexer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      token_kind,
  output logic [7:0]      word_length
);

  // Input register.
  logic                 held;
  logic [7:0]           char_q;

  // Running word state.
  logic                 in_word;
  awl_pkg::node_t       keyword_node;
  awl_pkg::status_t     integer_status;
  awl_pkg::status_t     register_status;
  logic                 label_valid;
  logic [7:0]           length_count;

  awl_pkg::node_t       keyword_node_next;
  awl_pkg::status_t     integer_status_next;
  awl_pkg::status_t     register_status_next;
  logic                 label_valid_next;
  awl_pkg::kind_t       kind_now;

  logic                 is_space;
  logic                 emits;
  logic                 advance;

  assign is_space = (char_q <= awl_pkg::SPACE_MAX);
  assign emits    = held && is_space && in_word;
  // The held byte moves on unless it ends a word and the result slot is full and not being read.
  assign advance  = held && (!emits || !out_valid || out_ready);
  assign in_ready = !held || advance;

  // Kind of the word collected so far, in priority order.
  always_comb begin
    if ((keyword_node >= awl_pkg::NODE_BR) && (keyword_node <= awl_pkg::NODE_BSE) &&
        ({6'd0, awl_pkg::mnem_len(keyword_node)} == length_count)) begin
      kind_now = keyword_node;
    end else if ((integer_status == awl_pkg::INT_ZERO) ||
                 (integer_status == awl_pkg::INT_DIGITS)) begin
      kind_now = awl_pkg::KIND_INT;
    end else if (register_status == awl_pkg::REG_R_DIGIT) begin
      kind_now = awl_pkg::KIND_REG;
    end else if (label_valid) begin
      kind_now = awl_pkg::KIND_LABEL;
    end else begin
      kind_now = awl_pkg::KIND_UNKNOWN;
    end
  end

  // Per-character updates of the recognizers.
  always_comb begin
    keyword_node_next = awl_pkg::next_node(keyword_node, length_count, char_q);

    case (integer_status)
      awl_pkg::INT_EMPTY: begin
        if (char_q == "0") begin
          integer_status_next = awl_pkg::INT_ZERO;
        end else if (awl_pkg::is_digit(char_q)) begin
          integer_status_next = awl_pkg::INT_DIGITS;
        end else begin
          integer_status_next = awl_pkg::INT_NONE;
        end
      end
      awl_pkg::INT_DIGITS: begin
        integer_status_next = awl_pkg::is_digit(char_q) ? awl_pkg::INT_DIGITS
                                                        : awl_pkg::INT_NONE;
      end
      default: integer_status_next = awl_pkg::INT_NONE;
    endcase

    case (register_status)
      awl_pkg::REG_EMPTY: begin
        register_status_next = (char_q == "r") ? awl_pkg::REG_R : awl_pkg::REG_NONE;
      end
      awl_pkg::REG_R: begin
        register_status_next = awl_pkg::is_digit(char_q) ? awl_pkg::REG_R_DIGIT
                                                         : awl_pkg::REG_NONE;
      end
      default: register_status_next = awl_pkg::REG_NONE;
    endcase

    if (!in_word) begin
      label_valid_next = label_valid && awl_pkg::is_label_start(char_q);
    end else begin
      label_valid_next = label_valid &&
                         (awl_pkg::is_label_start(char_q) || awl_pkg::is_digit(char_q));
    end
  end

  // Input register: takes a byte whenever it is empty or the previous one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_q <= char_code;
    end
  end

  // Word state: a word byte advances the DFA, whitespace clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word         <= 1'b0;
      keyword_node    <= awl_pkg::NODE_ROOT;
      integer_status  <= awl_pkg::INT_EMPTY;
      register_status <= awl_pkg::REG_EMPTY;
      label_valid     <= 1'b1;
      length_count    <= 8'd0;
    end else if (advance) begin
      if (is_space) begin
        in_word         <= 1'b0;
        keyword_node    <= awl_pkg::NODE_ROOT;
        integer_status  <= awl_pkg::INT_EMPTY;
        register_status <= awl_pkg::REG_EMPTY;
        label_valid     <= 1'b1;
        length_count    <= 8'd0;
      end else begin
        in_word         <= 1'b1;
        keyword_node    <= keyword_node_next;
        integer_status  <= integer_status_next;
        register_status <= register_status_next;
        label_valid     <= label_valid_next;
        if (length_count < awl_pkg::LEN_CAP) begin
          length_count <= length_count + 8'd1;
        end
      end
    end
  end

  // Result register: loaded when a word ends, freed on an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emits) begin
      token_kind  <= kind_now;
      word_length <= length_count;
    end
  end

endmodule

`default_nettype wire
